### rtl/mhid_pkg.sv
`timescale 1ns / 1ps
package mhid_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned TagWidth = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PLACE,
    ST_DUMP
  } mhid_state_e;

  typedef struct packed {
    logic [KeyWidth-1:0] key;
    logic [TagWidth-1:0] tag;
  } heap_entry_t;

  typedef struct packed {
    logic [TagWidth-1:0] letter;
    logic                last;
    logic                full;
  } out_word_t;

endpackage

### rtl/mhid_if.sv
`timescale 1ns / 1ps
interface mhid_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         entry_letter;
  logic signed [31:0] entry_priority;

  modport source (output valid, output entry_letter, output entry_priority, input ready);
  modport sink (input valid, input entry_letter, input entry_priority, output ready);
endinterface

interface mhid_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] heap_letter;
  logic       last_of_dump;
  logic       heap_full;

  modport source (output valid, output heap_letter, output last_of_dump, output heap_full,
                  input ready);
  modport sink (input valid, input heap_letter, input last_of_dump, input heap_full,
                output ready);
endinterface

### rtl/min_heap_insert_dump.sv
`timescale 1ns / 1ps
// Binary min-heap of (letter, priority) entries with insert-and-list.
// The input channel in_i carries one word per insert: a letter and a signed
// 32-bit priority. A word with priority zero is taken and has no effect.
// Any other word is appended and sifted up (strict less-than), after which
// the block lists every stored letter in array order on out_o, one word per
// entry, with last_of_dump set on the final word. If the heap already holds
// HEAP_DEPTH entries the insert is dropped and the listing carries heap_full.
// Keys and letters live in one single-port-read synchronous memory. Sift-up
// compares one level per ST_CMP step and, on reaching the root, writes the
// entry in ST_PLACE; the listing then streams one word per cycle from the
// memory read port through a two-word output queue. The next word is
// accepted once the last read of a listing has been issued.
// When the receiver stalls, the queue fills and memory reads pause; no word
// is lost. Reset empties the heap and the queue; memory contents are not
// cleared, since only positions below the entry count are ever read.
module min_heap_insert_dump #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  mhid_in_if.sink  in_i,
  mhid_out_if.source out_o
);
  import mhid_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

  heap_entry_t heap_mem [HEAP_DEPTH];
  heap_entry_t rdata_q;

  mhid_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  heap_entry_t   new_q, new_d;
  logic          full_q, full_d;

  logic          infl_vld_q, infl_last_q, infl_full_q;
  logic          issue, issue_last;

  out_word_t     fifo_q [2];
  logic          fifo_wr_q, fifo_rd_q;
  logic [1:0]    fifo_cnt_q;
  logic          push, pop;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  heap_entry_t   mem_wd;

  logic          accept, is_full, less;
  logic [AW-1:0] pos_parent, cnt_parent, grand_parent;
  logic [2:0]    occ;

  assign accept       = in_i.valid && in_i.ready;
  assign is_full      = (count_q == CW'(HEAP_DEPTH));
  assign cnt_parent   = AW'((count_q - 1'b1) >> 1);
  assign pos_parent   = AW'((pos_q - 1'b1) >> 1);
  assign grand_parent = AW'((pos_parent - 1'b1) >> 1);
  assign less         = $signed(new_q.key) < $signed(rdata_q.key);

  assign pop  = out_o.valid && out_o.ready;
  assign push = infl_vld_q;
  assign occ  = 3'(fifo_cnt_q) + 3'(infl_vld_q) - 3'(pop);
  assign issue      = (state_q == ST_DUMP) && (occ < 3'd2);
  assign issue_last = ((rd_cnt_q + 1'b1) == count_q);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_cnt_d = rd_cnt_q;
    pos_d    = pos_q;
    new_d    = new_q;
    full_d   = full_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.entry_priority != '0)) begin
          new_d.key = in_i.entry_priority;
          new_d.tag = in_i.entry_letter;
          rd_cnt_d  = '0;
          pos_d     = count_q[AW-1:0];
          if (is_full) begin
            full_d  = 1'b1;
            state_d = ST_DUMP;
          end else begin
            full_d  = 1'b0;
            count_d = count_q + 1'b1;
            state_d = (count_q == '0) ? ST_DUMP : ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (less) begin
          pos_d = pos_parent;
          if (pos_parent == '0) begin
            state_d = ST_PLACE;
          end
        end else begin
          state_d = ST_DUMP;
        end
      end
      ST_PLACE: begin
        state_d = ST_DUMP;
      end
      ST_DUMP: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
          if (issue_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = pos_q;
    mem_ra = pos_parent;
    mem_wd = new_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.entry_priority != '0) && !is_full) begin
          if (count_q == '0) begin
            mem_we     = 1'b1;
            mem_wa     = '0;
            mem_wd.key = in_i.entry_priority;
            mem_wd.tag = in_i.entry_letter;
          end else begin
            mem_re = 1'b1;
            mem_ra = cnt_parent;
          end
        end
      end
      ST_CMP: begin
        mem_we = 1'b1;
        mem_wa = pos_q;
        if (less) begin
          mem_wd = rdata_q;
          if (pos_parent != '0) begin
            mem_re = 1'b1;
            mem_ra = grand_parent;
          end
        end
      end
      ST_PLACE: begin
        mem_we = 1'b1;
        mem_wa = '0;
      end
      ST_DUMP: begin
        mem_re = issue;
        mem_ra = rd_cnt_q[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= heap_mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      full_q      <= 1'b0;
      infl_vld_q  <= 1'b0;
      infl_last_q <= 1'b0;
      infl_full_q <= 1'b0;
      fifo_wr_q   <= 1'b0;
      fifo_rd_q   <= 1'b0;
      fifo_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      full_q      <= full_d;
      infl_vld_q  <= issue;
      infl_last_q <= issue_last;
      infl_full_q <= full_q;
      if (push) begin
        fifo_wr_q <= ~fifo_wr_q;
      end
      if (pop) begin
        fifo_rd_q <= ~fifo_rd_q;
      end
      fifo_cnt_q <= 2'(3'(fifo_cnt_q) + 3'(push) - 3'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    new_q <= new_d;
    if (push) begin
      fifo_q[fifo_wr_q].letter <= rdata_q.tag;
      fifo_q[fifo_wr_q].last   <= infl_last_q;
      fifo_q[fifo_wr_q].full   <= infl_full_q;
    end
  end

  assign out_o.valid        = (fifo_cnt_q != '0);
  assign out_o.heap_letter  = fifo_q[fifo_rd_q].letter;
  assign out_o.last_of_dump = fifo_q[fifo_rd_q].last;
  assign out_o.heap_full    = fifo_q[fifo_rd_q].full;

endmodule

### bench/mhid_checker.sv
`timescale 1ns / 1ps
module mhid_checker #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  mhid_in_if   in_mon,
  mhid_out_if  out_mon,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   inserts_o,
  output int   words_o,
  output int   full_lists_o
);
  import mhid_pkg::*;

  logic signed [KeyWidth-1:0] heap_key [HEAP_DEPTH];
  logic [TagWidth-1:0]        heap_tag [HEAP_DEPTH];
  int unsigned                heap_size;
  out_word_t                  listing_q[$];

  int fail_cnt = 0;
  int inserts_seen = 0;
  int words_seen = 0;
  int full_lists = 0;

  assign fail_cnt_o   = fail_cnt;
  assign pending_o    = listing_q.size();
  assign inserts_o    = inserts_seen;
  assign words_o      = words_seen;
  assign full_lists_o = full_lists;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  // A new entry climbs while its key is strictly below its parent's, so ties
  // never move. The whole array is then listed, root first.
  function automatic void predict_insert(input logic [TagWidth-1:0] letter,
                                         input logic signed [KeyWidth-1:0] prio);
    int unsigned                pos;
    int unsigned                parent;
    logic signed [KeyWidth-1:0] key_tmp;
    logic [TagWidth-1:0]        tag_tmp;
    logic                       dropped;
    out_word_t                  w;
    if (prio == 0) return;
    inserts_seen++;
    dropped = (heap_size >= HEAP_DEPTH);
    if (dropped) begin
      full_lists++;
    end else begin
      heap_key[heap_size] = prio;
      heap_tag[heap_size] = letter;
      pos = heap_size;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (!(heap_key[pos] < heap_key[parent])) break;
        key_tmp          = heap_key[pos];
        tag_tmp          = heap_tag[pos];
        heap_key[pos]    = heap_key[parent];
        heap_tag[pos]    = heap_tag[parent];
        heap_key[parent] = key_tmp;
        heap_tag[parent] = tag_tmp;
        pos = parent;
      end
      heap_size++;
    end
    for (int p = 0; p < heap_size; p++) begin
      w.letter = heap_tag[p];
      w.last   = (p == heap_size - 1);
      w.full   = dropped;
      listing_q.push_back(w);
    end
  endfunction

  task automatic check_word();
    out_word_t want;
    if (listing_q.size() == 0) begin
      report($sformatf("unexpected word, letter %02h last %0b full %0b",
                       out_mon.heap_letter, out_mon.last_of_dump, out_mon.heap_full));
      return;
    end
    want = listing_q.pop_front();
    words_seen++;
    if (out_mon.heap_letter !== want.letter)
      report($sformatf("word %0d letter %02h, expected %02h",
                       words_seen, out_mon.heap_letter, want.letter));
    if (out_mon.last_of_dump !== want.last)
      report($sformatf("word %0d last_of_dump %0b, expected %0b",
                       words_seen, out_mon.last_of_dump, want.last));
    if (out_mon.heap_full !== want.full)
      report($sformatf("word %0d heap_full %0b, expected %0b",
                       words_seen, out_mon.heap_full, want.full));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_size = 0;
      listing_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_word();
      if (in_mon.valid && in_mon.ready) predict_insert(in_mon.entry_letter, in_mon.entry_priority);
    end
  end

endmodule

### bench/tb_min_heap_insert_dump.sv
`timescale 1ns / 1ps
module tb_min_heap_insert_dump;
  import mhid_pkg::*;

  localparam int unsigned HeapDepth     = 64;
  localparam int unsigned CycleLimit    = 2000000;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned RandomInserts = 255;

  logic        clk_i;
  logic        rst_ni;
  logic        hold_off;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned no_gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned steady_left = 0;

  int fail_cnt;
  int pending_cnt;
  int inserts_seen;
  int words_seen;
  int full_lists;

  mhid_in_if  in_if ();
  mhid_out_if out_if ();

  min_heap_insert_dump #(
    .HEAP_DEPTH(HeapDepth)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  mhid_checker #(
    .HEAP_DEPTH(HeapDepth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt),
    .inserts_o   (inserts_seen),
    .words_o     (words_seen),
    .full_lists_o(full_lists)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_cnt, pending_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_entry(input logic [TagWidth-1:0] letter,
                            input logic signed [KeyWidth-1:0] prio);
    int unsigned gap;
    int unsigned pick;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (no_gap_left > 0) no_gap_left--;
    else if (pick < 3) no_gap_left = $urandom_range(20, 60);
    else if (pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.entry_letter   <= letter;
    in_if.entry_priority <= prio;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  function automatic logic signed [KeyWidth-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 1) return '0;
    else if (sel < 5) return int'($urandom_range(0, 16)) - 8;
    else if (sel < 8) return $urandom;
    else if (sel < 9) return 32'sh8000_0000 + int'($urandom_range(0, 3));
    else return 32'sh7FFF_FFFF - int'($urandom_range(0, 3));
  endfunction

  // The receiver is held off for a long stretch once 80 words have been sent,
  // so the output queue backs up while the sender keeps offering words.
  initial begin
    hold_off <= 1'b0;
    wait (items_sent >= 80);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    int unsigned pick;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        pick = $urandom_range(0, 99);
        if (steady_left > 0) steady_left--;
        else if (pick < 2) steady_left = $urandom_range(50, 200);
        else if (pick < 20) stall_left = $urandom_range(1, 3);
        else if (pick < 24) stall_left = $urandom_range(8, 20);
      end
    end
  end

  initial begin
    int unsigned                nonzero_sent;
    logic signed [KeyWidth-1:0] prio;
    nonzero_sent          = 0;
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.entry_letter   <= '0;
    in_if.entry_priority <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero priority is ignored, on an empty heap and later on a non-empty one.
    send_entry(8'h61, 32'sh0000_0000);
    send_entry(8'h00, 32'sh7FFF_FFFF);
    send_entry(8'hFF, 32'sh8000_0000);
    send_entry(8'h55, -32'sd1);
    send_entry(8'hAA, 32'sd1);
    send_entry(8'h62, 32'sd5);
    send_entry(8'h63, 32'sd5);
    send_entry(8'h64, 32'sd5);
    send_entry(8'h65, -32'sd1);
    send_entry(8'hFF, 32'sh0000_0000);
    send_entry(8'h66, 32'sh8000_0000);
    send_entry(8'h67, 32'sh7FFF_FFFE);
    send_entry(8'h80, 32'sh8000_0001);
    send_entry(8'h7F, 32'sh0000_0000);

    while (nonzero_sent < RandomInserts) begin
      prio = pick_priority();
      send_entry(8'($urandom_range(0, 255)), prio);
      if (prio != 0) nonzero_sent++;
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Offered %0d words, %0d of them inserts; checked %0d listed letters.",
             items_sent, inserts_seen, words_seen);
    $display("%0d listings came from a full heap, one receiver hold of %0d cycles.",
             full_lists, HoldCycles);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### min_heap_insert_dump.f
rtl/mhid_pkg.sv
rtl/mhid_if.sv
rtl/min_heap_insert_dump.sv
bench/mhid_checker.sv
bench/tb_min_heap_insert_dump.sv
